// ===== sv/deq_pkg.sv =====
package deq_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int DATA_W = 32;
	localparam int CMD_W = 3;
	localparam int STAT_W = 2;

	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_REAR = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_REAR = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LIST = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
	localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd1;
	localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

	localparam logic [IDX_W:0] CAP_EXT = (IDX_W + 1)'(CAPACITY);
	localparam logic [IDX_W-1:0] CAP_M1 = IDX_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_POP  = 3'b010,
		ST_LIST = 3'b100
	} state_t;

	// Adds two indices that are each below the capacity and wraps the sum once.
	function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
		logic [IDX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= CAP_EXT) begin
			s = s - CAP_EXT;
		end
		return s[IDX_W-1:0];
	endfunction

endpackage

// ===== sv/double_ended_queue_core.sv =====
// A push, an overflow, an underflow or a list of an empty queue gives its result beat
// in the cycle after the command is taken.
// A pop passes through the ST_POP state before its result beat because the element store has a registered read port.
// A list of N elements passes through ST_LIST and gives N beats, one beat per cycle.
// The receiver cannot stall; busy is high while a pop or a list is in progress.
// Reset empties the queue and clears the front index; stored values are not cleared.
module double_ended_queue_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [deq_pkg::CMD_W-1:0]            cmd,
	input  logic signed [deq_pkg::DATA_W-1:0]    push_value,
	output logic                                 result_valid,
	output logic signed [deq_pkg::DATA_W-1:0]    data_value,
	output logic [deq_pkg::STAT_W-1:0]           status,
	output logic                                 last_result
);

	import deq_pkg::*;

	state_t state_q;
	logic [IDX_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] list_idx_q;
	logic valid_q;
	logic [DATA_W-1:0] data_q;
	logic [STAT_W-1:0] status_q;
	logic last_q;

	logic accept;
	logic full;
	logic empty;
	logic list_last;
	logic [IDX_W-1:0] add_off;
	logic [IDX_W-1:0] sum;
	logic ram_we;
	logic [IDX_W-1:0] ram_rd_addr;
	logic [DATA_W-1:0] ram_rd_data;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && (state_q == ST_IDLE);
	assign full = (count_q == CAP_CNT);
	assign empty = (count_q == '0);
	assign list_last = (({1'b0, list_idx_q} + CNT_W'(1)) == count_q);

	// The single wrapping index adder serves every front-pointer update and every computed store address.
	always_comb begin
		add_off = '0;
		case (state_q)
			ST_LIST: begin
				add_off = list_idx_q + IDX_W'(1);
			end
			ST_IDLE: begin
				case (cmd)
					CMD_PUSH_FRONT: add_off = CAP_M1;
					CMD_PUSH_REAR: add_off = count_q[IDX_W-1:0];
					CMD_POP_FRONT: add_off = IDX_W'(1);
					CMD_POP_REAR: add_off = count_q[IDX_W-1:0] - IDX_W'(1);
					default: add_off = '0;
				endcase
			end
			default: add_off = '0;
		endcase
	end

	assign sum = wrap_add(front_q, add_off);
	assign ram_rd_addr = ((state_q == ST_LIST) || (cmd == CMD_POP_REAR)) ? sum : front_q;
	assign ram_we = accept && !full && ((cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_REAR));

	deq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk(clk),
		.wr_en(ram_we),
		.wr_addr(sum),
		.wr_data(push_value),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			front_q <= '0;
			count_q <= '0;
			list_idx_q <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_PUSH_FRONT: begin
								valid_q <= 1'b1;
								if (!full) begin
									front_q <= sum;
									count_q <= count_q + CNT_W'(1);
								end
							end
							CMD_PUSH_REAR: begin
								valid_q <= 1'b1;
								if (!full) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							CMD_POP_FRONT: begin
								if (empty) begin
									valid_q <= 1'b1;
								end else begin
									front_q <= sum;
									count_q <= count_q - CNT_W'(1);
									state_q <= ST_POP;
								end
							end
							CMD_POP_REAR: begin
								if (empty) begin
									valid_q <= 1'b1;
								end else begin
									count_q <= count_q - CNT_W'(1);
									state_q <= ST_POP;
								end
							end
							CMD_LIST: begin
								list_idx_q <= '0;
								if (empty) begin
									valid_q <= 1'b1;
								end else begin
									state_q <= ST_LIST;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_POP: begin
					valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_LIST: begin
					valid_q <= 1'b1;
					list_idx_q <= list_idx_q + IDX_W'(1);
					if (list_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				data_q <= '0;
				last_q <= 1'b1;
				case (cmd)
					CMD_PUSH_FRONT, CMD_PUSH_REAR: status_q <= full ? STAT_OVERFLOW : STAT_OK;
					CMD_POP_FRONT, CMD_POP_REAR: status_q <= STAT_UNDERFLOW;
					CMD_LIST: status_q <= STAT_EMPTY;
					default: status_q <= STAT_OK;
				endcase
			end
			ST_POP: begin
				data_q <= ram_rd_data;
				status_q <= STAT_OK;
				last_q <= 1'b1;
			end
			ST_LIST: begin
				data_q <= ram_rd_data;
				status_q <= STAT_OK;
				last_q <= list_last;
			end
			default: begin
				data_q <= '0;
				status_q <= STAT_OK;
				last_q <= 1'b1;
			end
		endcase
	end

	assign result_valid = valid_q;
	assign data_value = data_q;
	assign status = status_q;
	assign last_result = last_q;

endmodule

// ===== sv/deq_ram.sv =====
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
